// ===== src/afsc_pkg.sv =====
// Package: shared constants and types for the feeder step controller.
package afsc_pkg;
  localparam int ANGLE_FRAC_BITS = 6;
  localparam int STEP_COUNT_BITS = 16;
  localparam int PRESS_LEVEL = 200;
  localparam int JAM_TOL_DEG = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_FEED_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CONT_SPEED = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BURST_COUNT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_DELAY = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_PITCH = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_REVERSE_ANGLE = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_TIME = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_REVERSE = 3'd7;

  localparam logic [1:0] MODE_SAFE = 2'd0;
  localparam logic [1:0] MODE_SPEED = 2'd1;
  localparam logic [1:0] MODE_BURST = 2'd2;
  localparam logic [1:0] MODE_SINGLE = 2'd3;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_ANGLE = 2'd1;
  localparam logic [1:0] KIND_SPEED = 2'd2;
  localparam logic [1:0] KIND_SAFE = 2'd3;

  typedef struct packed {
    logic [31:0]        now_ms;
    logic signed [15:0] trigger_level;
    logic signed [31:0] soft_angle;
    logic signed [31:0] real_angle;
    logic               jam_detected;
    logic               speed_target_negative;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         drive_kind;
    logic signed [31:0] angle_setpoint;
    logic signed [15:0] speed_setpoint;
    logic               clear_jam;
    logic               bus_send;
  } out_item_t;

  typedef struct packed {
    logic        start;
    logic [33:0] dividend;
    logic [14:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [33:0] quotient;
  } div_rsp_t;
endpackage

// ===== src/afsc_if.sv =====
// Interfaces: valid/ready channels for input ticks and result commands.
interface afsc_in_if;
  logic valid;
  logic ready;
  afsc_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface afsc_out_if;
  logic valid;
  logic ready;
  afsc_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== src/afsc_div.sv =====
// Restoring divider: one quotient bit per cycle, used by the overshoot trim.
module afsc_div (
  input  logic                clk,
  input  logic                rst,
  input  afsc_pkg::div_req_t  req,
  output afsc_pkg::div_rsp_t  rsp
);
  logic [33:0] quo;
  logic [15:0] rem;
  logic [14:0] dvs;
  logic [5:0]  cnt;
  logic        busy;
  logic        done;
  logic [15:0] trial;
  logic [15:0] sub;

  always_comb begin
    trial = {rem[14:0], quo[33]};
    sub = trial - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      quo <= req.dividend;
      dvs <= req.divisor;
      rem <= '0;
      cnt <= 6'd34;
    end else if (busy) begin
      if (trial >= {1'b0, dvs}) begin
        rem <= sub;
        quo <= {quo[32:0], 1'b1};
      end else begin
        rem <= trial;
        quo <= {quo[32:0], 1'b0};
      end
      cnt <= cnt - 6'd1;
      if (cnt == 6'd1) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quotient = quo;
endmodule

// ===== src/ammo_feeder_step_controller.sv =====
// Top level: feeder step controller with sequencer, state and result register.
// Usage: one control tick enters on the in channel (valid/ready transfer);
// one motor command leaves on the out channel for every tick. The user must
// write the configuration registers through cfg_we/cfg_index/cfg_data only
// while idle; the block itself does not enforce it. A tick passes through
// S_JAM, S_MODE and S_OUT for safe, speed and jam ticks, with S_POS before
// S_OUT in the burst and single modes; when the overshoot trim runs, S_DIV
// follows S_POS and waits for the bit-serial divider (one quotient bit a
// cycle over 34 bits). in.ready is low while a tick is worked on. The result
// sits in an output register; while the receiver stalls the block holds it
// and takes the next tick, but finishes that one only once the register is
// free. Reset (rst, synchronous, active high) idles the sequencer, clears
// the feeder state, restores the register defaults and drops out.valid.
module ammo_feeder_step_controller #(
  parameter int ANGLE_FRAC_BITS = afsc_pkg::ANGLE_FRAC_BITS,
  parameter int STEP_COUNT_BITS = afsc_pkg::STEP_COUNT_BITS
) (
  input  logic                             clk,
  input  logic                             rst,
  afsc_in_if.sink                          in,
  afsc_out_if.source                       out,
  input  logic                             cfg_we,
  input  logic [afsc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [afsc_pkg::CFG_DATA_W-1:0]  cfg_data
);
  localparam logic [STEP_COUNT_BITS-1:0] STEP_MAX = '1;
  localparam logic signed [33:0] JAM_TOL = 34'(afsc_pkg::JAM_TOL_DEG) <<< ANGLE_FRAC_BITS;

  typedef enum logic [2:0] {S_IDLE, S_JAM, S_MODE, S_POS, S_DIV, S_OUT} state_t;
  state_t state;

  logic [1:0]  feed_mode;
  logic [15:0] continuous_speed;
  logic [7:0]  burst_count;
  logic [15:0] step_delay_ms;
  logic [14:0] step_pitch;
  logic [14:0] reverse_angle;
  logic [15:0] hold_time_ms;
  logic        direction_reverse;

  logic [1:0]  previous_mode;
  logic [31:0] target_angle;
  logic        jam_in_progress;
  logic [STEP_COUNT_BITS-1:0] steps_pending;
  logic [31:0] last_step_time;
  logic        press_active;
  logic [31:0] press_time;
  logic        short_press_pending;
  logic        burst_armed;

  afsc_pkg::in_item_t  it;
  logic        blocked;
  logic [1:0]  kind;
  logic        clr;
  logic [15:0] spd;
  logic        send;
  logic [31:0] pitch_signed;

  afsc_pkg::div_req_t dreq;
  afsc_pkg::div_rsp_t drsp;

  afsc_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  logic signed [33:0] jam_diff;
  logic signed [33:0] jam_abs;
  logic               pressed;
  logic signed [33:0] trim_d;
  logic [31:0]        trim_prod;

  always_comb begin
    jam_diff = 34'(it.soft_angle) - 34'($signed(target_angle));
    jam_abs = jam_diff[33] ? -jam_diff : jam_diff;
    pressed = it.trigger_level > 16'(afsc_pkg::PRESS_LEVEL);
    trim_d = direction_reverse ? 34'(it.soft_angle) - 34'($signed(target_angle))
                               : 34'($signed(target_angle)) - 34'(it.soft_angle);
    pitch_signed = direction_reverse ? -{17'd0, step_pitch} : {17'd0, step_pitch};
    trim_prod = 32'(drsp.quotient[31:0] * {17'd0, step_pitch});
  end

  assign in.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    dreq.start <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
      out.valid <= 1'b0;
      feed_mode <= afsc_pkg::MODE_SAFE;
      continuous_speed <= '0;
      burst_count <= 8'd3;
      step_delay_ms <= 16'd100;
      step_pitch <= 15'd2880;
      reverse_angle <= 15'd2880;
      hold_time_ms <= 16'd300;
      direction_reverse <= 1'b0;
      previous_mode <= '0;
      target_angle <= '0;
      jam_in_progress <= 1'b0;
      steps_pending <= '0;
      last_step_time <= '0;
      press_active <= 1'b0;
      press_time <= '0;
      short_press_pending <= 1'b0;
      burst_armed <= 1'b0;
    end else begin
      if (out.valid && out.ready) out.valid <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          afsc_pkg::REG_FEED_MODE:     feed_mode <= cfg_data[1:0];
          afsc_pkg::REG_CONT_SPEED:    continuous_speed <= cfg_data;
          afsc_pkg::REG_BURST_COUNT:   burst_count <= cfg_data[7:0];
          afsc_pkg::REG_STEP_DELAY:    step_delay_ms <= cfg_data;
          afsc_pkg::REG_STEP_PITCH:    step_pitch <= cfg_data[14:0];
          afsc_pkg::REG_REVERSE_ANGLE: reverse_angle <= cfg_data[14:0];
          afsc_pkg::REG_HOLD_TIME:     hold_time_ms <= cfg_data;
          afsc_pkg::REG_DIR_REVERSE:   direction_reverse <= cfg_data[0];
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (in.valid) begin
            it <= in.data;
            state <= S_JAM;
          end
        end
        S_JAM: begin
          kind <= afsc_pkg::KIND_NONE;
          clr <= 1'b0;
          blocked <= 1'b1;
          spd <= '0;
          send <= 1'b0;
          if (it.jam_detected) begin
            clr <= 1'b1;
            if (!jam_in_progress) begin
              target_angle <= it.speed_target_negative
                ? it.soft_angle + {17'd0, reverse_angle}
                : it.soft_angle - {17'd0, reverse_angle};
              kind <= afsc_pkg::KIND_ANGLE;
              jam_in_progress <= 1'b1;
            end else begin
              jam_in_progress <= 1'b0;
            end
          end else if (jam_in_progress) begin
            if (jam_abs <= JAM_TOL) jam_in_progress <= 1'b0;
            else kind <= afsc_pkg::KIND_ANGLE;
          end else begin
            blocked <= 1'b0;
            if (feed_mode != previous_mode) target_angle <= it.soft_angle;
          end
          previous_mode <= feed_mode;
          state <= S_MODE;
        end
        S_MODE: begin
          state <= S_OUT;
          if (!blocked) begin
            case (feed_mode)
              afsc_pkg::MODE_SPEED: begin
                kind <= afsc_pkg::KIND_SPEED;
                spd <= continuous_speed;
                send <= 1'b1;
                target_angle <= it.real_angle;
              end
              afsc_pkg::MODE_BURST: begin
                if (pressed) begin
                  if (!burst_armed) begin
                    steps_pending <= STEP_COUNT_BITS'(burst_count);
                    burst_armed <= 1'b1;
                  end
                end else begin
                  burst_armed <= 1'b0;
                end
                kind <= afsc_pkg::KIND_ANGLE;
                send <= 1'b1;
                state <= S_POS;
              end
              afsc_pkg::MODE_SINGLE: begin
                if (pressed) begin
                  if (!press_active) begin
                    press_active <= 1'b1;
                    press_time <= it.now_ms;
                  end
                  if (press_active && (it.now_ms - press_time) > {16'd0, hold_time_ms}) begin
                    if (steps_pending != STEP_MAX) steps_pending <= steps_pending + 1'b1;
                  end else begin
                    short_press_pending <= 1'b1;
                  end
                end else begin
                  press_active <= 1'b0;
                  steps_pending <= short_press_pending ? STEP_COUNT_BITS'(1) : '0;
                  short_press_pending <= 1'b0;
                end
                kind <= afsc_pkg::KIND_ANGLE;
                send <= 1'b1;
                state <= S_POS;
              end
              default: kind <= afsc_pkg::KIND_SAFE;
            endcase
          end
        end
        S_POS: begin
          state <= S_OUT;
          if ((it.now_ms - last_step_time) > {16'd0, step_delay_ms}) begin
            if (steps_pending != '0) begin
              target_angle <= target_angle + pitch_signed;
              steps_pending <= steps_pending - 1'b1;
              last_step_time <= it.now_ms;
            end else if (step_pitch != '0 && !trim_d[33] && trim_d != '0) begin
              dreq.dividend <= trim_d;
              dreq.divisor <= step_pitch;
              dreq.start <= 1'b1;
              state <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (drsp.done) begin
            target_angle <= direction_reverse ? target_angle + trim_prod
                                              : target_angle - trim_prod;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out.valid || out.ready) begin
            out.valid <= 1'b1;
            out.data.drive_kind <= kind;
            out.data.angle_setpoint <= (kind == afsc_pkg::KIND_ANGLE) ? target_angle : '0;
            out.data.speed_setpoint <= (kind == afsc_pkg::KIND_SPEED) ? spd : '0;
            out.data.clear_jam <= clr;
            out.data.bus_send <= send;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in.ready |-> state == S_IDLE) else $error("ready outside idle");
  a_one_result: assert property (@(posedge clk) disable iff (rst)
    (in.valid && in.ready) |=> !in.ready) else $error("second tick taken");
  a_div_only_trim: assert property (@(posedge clk) disable iff (rst)
    drsp.done |-> state == S_DIV) else $error("divider result unused");
endmodule

// ===== test/tb_ammo_feeder_step_controller.sv =====
// Testbench for the feeder step controller: directed and random ticks checked against a predictor.
`timescale 1ns / 1ps

module tb_ammo_feeder_step_controller;

  class cmd_scoreboard;
    logic [1:0]  mode, prev_mode;
    bit          dir_rev;
    logic [15:0] cont_speed, step_delay, hold_time;
    logic [afsc_pkg::STEP_COUNT_BITS-1:0] steps_pending;
    logic [7:0]  burst_count;
    logic [14:0] pitch, rev_angle;
    logic [31:0] target, last_step, press_time;
    bit jam_busy, press_active, short_pending, burst_armed;
    afsc_pkg::out_item_t pending_cmds[$];
    int errors;

    function new();
      errors = 0;
      mode = afsc_pkg::MODE_SAFE; cont_speed = 0; burst_count = 3; step_delay = 100;
      pitch = 2880; rev_angle = 2880; hold_time = 300; dir_rev = 0;
      prev_mode = 0; target = 0; jam_busy = 0; steps_pending = 0;
      last_step = 0; press_active = 0; press_time = 0;
      short_pending = 0; burst_armed = 0;
    endfunction

    function void write_reg(logic [afsc_pkg::CFG_IDX_W-1:0] idx, logic [15:0] v);
      case (idx)
        afsc_pkg::REG_FEED_MODE: mode = v[1:0];
        afsc_pkg::REG_CONT_SPEED: cont_speed = v;
        afsc_pkg::REG_BURST_COUNT: burst_count = v[7:0];
        afsc_pkg::REG_STEP_DELAY: step_delay = v;
        afsc_pkg::REG_STEP_PITCH: pitch = v[14:0];
        afsc_pkg::REG_REVERSE_ANGLE: rev_angle = v[14:0];
        afsc_pkg::REG_HOLD_TIME: hold_time = v;
        afsc_pkg::REG_DIR_REVERSE: dir_rev = v[0];
        default: ;
      endcase
    endfunction

    function void advance_position(logic [31:0] now, longint soft_pos);
      longint dir, p, d, q;
      logic [31:0] elapsed;
      dir = dir_rev ? -1 : 1;
      p = pitch;
      elapsed = now - last_step;
      if (elapsed > {16'd0, step_delay}) begin
        if (steps_pending != 0) begin
          target = target + 32'(dir * p);
          steps_pending = steps_pending - 1'b1;
          last_step = now;
        end else if (p > 0) begin
          d = (longint'($signed(target)) - soft_pos) * dir;
          if (d > 0) begin
            q = d / p;
            target = 32'(longint'($signed(target)) - dir * p * q);
          end
        end
      end
    endfunction

    function void note_tick(afsc_pkg::in_item_t t);
      afsc_pkg::out_item_t c;
      longint soft_pos, d;
      bit blocked, pressed;
      logic [31:0] held;
      c = '0;
      blocked = 1;
      soft_pos = longint'(t.soft_angle);
      pressed = t.trigger_level > afsc_pkg::PRESS_LEVEL;
      if (t.jam_detected) begin
        c.clear_jam = 1;
        if (!jam_busy) begin
          target = t.speed_target_negative ? 32'(soft_pos + rev_angle)
                                           : 32'(soft_pos - rev_angle);
          c.drive_kind = afsc_pkg::KIND_ANGLE;
          jam_busy = 1;
        end else jam_busy = 0;
      end else if (jam_busy) begin
        d = soft_pos - longint'($signed(target));
        if (d < 0) d = -d;
        if (d <= (afsc_pkg::JAM_TOL_DEG << afsc_pkg::ANGLE_FRAC_BITS)) jam_busy = 0;
        else c.drive_kind = afsc_pkg::KIND_ANGLE;
      end else blocked = 0;
      if (!blocked) begin
        if (mode != prev_mode) target = t.soft_angle;
        case (mode)
          afsc_pkg::MODE_SPEED: begin
            c.drive_kind = afsc_pkg::KIND_SPEED; c.speed_setpoint = cont_speed;
            c.bus_send = 1;
            target = t.real_angle;
          end
          afsc_pkg::MODE_BURST: begin
            if (pressed) begin
              if (!burst_armed) begin
                steps_pending = afsc_pkg::STEP_COUNT_BITS'(burst_count);
                burst_armed = 1;
              end
            end else burst_armed = 0;
            advance_position(t.now_ms, soft_pos);
            c.drive_kind = afsc_pkg::KIND_ANGLE; c.bus_send = 1;
          end
          afsc_pkg::MODE_SINGLE: begin
            if (pressed) begin
              if (!press_active) begin
                press_active = 1; press_time = t.now_ms;
              end
            end else press_active = 0;
            if (press_active) begin
              held = t.now_ms - press_time;
              if (held > {16'd0, hold_time}) begin
                if (steps_pending != '1) steps_pending = steps_pending + 1'b1;
              end else short_pending = 1;
            end else begin
              steps_pending = short_pending ? afsc_pkg::STEP_COUNT_BITS'(1) : '0;
              short_pending = 0;
            end
            advance_position(t.now_ms, soft_pos);
            c.drive_kind = afsc_pkg::KIND_ANGLE; c.bus_send = 1;
          end
          default: c.drive_kind = afsc_pkg::KIND_SAFE;
        endcase
      end
      prev_mode = mode;
      if (c.drive_kind == afsc_pkg::KIND_ANGLE) c.angle_setpoint = target;
      pending_cmds.push_back(c);
    endfunction

    function void check_cmd(afsc_pkg::out_item_t a);
      afsc_pkg::out_item_t e;
      if (pending_cmds.size() == 0) begin
        $error("unexpected command %h", a);
        errors++;
        return;
      end
      e = pending_cmds.pop_front();
      if (a.drive_kind !== e.drive_kind) begin
        $error("drive_kind exp %0d got %0d", e.drive_kind, a.drive_kind); errors++;
      end
      if (a.angle_setpoint !== e.angle_setpoint) begin
        $error("angle_setpoint exp %0d got %0d", e.angle_setpoint, a.angle_setpoint);
        errors++;
      end
      if (a.speed_setpoint !== e.speed_setpoint) begin
        $error("speed_setpoint exp %0d got %0d", e.speed_setpoint, a.speed_setpoint);
        errors++;
      end
      if (a.clear_jam !== e.clear_jam) begin
        $error("clear_jam exp %0d got %0d", e.clear_jam, a.clear_jam); errors++;
      end
      if (a.bus_send !== e.bus_send) begin
        $error("bus_send exp %0d got %0d", e.bus_send, a.bus_send); errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [afsc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [afsc_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  bit calm = 0;
  bit sink_run = 0;

  afsc_in_if in_ch();
  afsc_out_if out_ch();

  ammo_feeder_step_controller u_top (
    .clk(clk), .rst(rst), .in(in_ch), .out(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  cmd_scoreboard sb = new();
  logic [31:0] clock_ms;
  logic signed [31:0] shaft;

  initial begin
    in_ch.valid = 0;
    in_ch.data = '0;
    out_ch.ready = 0;
  end

  initial forever #5 clk = ~clk;

  always @(posedge clk) begin
    if (sink_run) out_ch.ready <= calm || ($urandom_range(99) >= 14);
    if (!rst && out_ch.valid && out_ch.ready) sb.check_cmd(out_ch.data);
  end

  task automatic write_reg(logic [afsc_pkg::CFG_IDX_W-1:0] idx, logic [15:0] v);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= v;
    sb.write_reg(idx, v);
    @(posedge clk);
    cfg_we <= 0;
    @(posedge clk);
  endtask

  task automatic send_tick(afsc_pkg::in_item_t t);
    while (!calm && $urandom_range(99) < 14) @(posedge clk);
    in_ch.valid <= 1;
    in_ch.data <= t;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_tick(t);
    in_ch.valid <= 0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (sb.pending_cmds.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  // mostly small realistic steps, some wild values
  task automatic random_tick(bit wild);
    afsc_pkg::in_item_t t;
    if (wild) begin
      t.now_ms = $urandom;
      t.trigger_level = $urandom;
      t.soft_angle = $urandom;
      t.real_angle = $urandom;
      t.jam_detected = $urandom_range(1);
    end else begin
      clock_ms = clock_ms + $urandom_range(60);
      shaft = shaft + $signed($urandom_range(400)) - 200;
      t.now_ms = clock_ms;
      t.trigger_level = ($urandom_range(2) != 0) ? 16'sd201 + $urandom_range(3000)
                                                 : 16'sd200 - $urandom_range(3000);
      t.soft_angle = shaft;
      t.real_angle = shaft + $signed($urandom_range(100));
      t.jam_detected = ($urandom_range(19) == 0);
    end
    t.speed_target_negative = $urandom_range(1);
    send_tick(t);
  endtask

  task automatic random_config(bit extreme);
    write_reg(afsc_pkg::REG_FEED_MODE, $urandom_range(3));
    write_reg(afsc_pkg::REG_CONT_SPEED, $urandom);
    write_reg(afsc_pkg::REG_BURST_COUNT, extreme ? 16'd255 : $urandom_range(8));
    write_reg(afsc_pkg::REG_STEP_DELAY, extreme ? 16'hFFFF : $urandom_range(150));
    write_reg(afsc_pkg::REG_STEP_PITCH, extreme ? 16'd23040 : 16'd1 + $urandom_range(5000));
    write_reg(afsc_pkg::REG_REVERSE_ANGLE, extreme ? 16'd23040 : $urandom_range(5000));
    write_reg(afsc_pkg::REG_HOLD_TIME, extreme ? 16'hFFFF : $urandom_range(400));
    write_reg(afsc_pkg::REG_DIR_REVERSE, $urandom_range(1));
  endtask

  initial begin
    afsc_pkg::in_item_t t;
    clock_ms = 0;
    shaft = 0;
    repeat (8) @(posedge clk);
    rst <= 0;
    sink_run = 1;
    @(posedge clk);
    // directed: every mode, jams, field extremes, overflowed clock
    for (int m = 0; m < 4; m++) begin
      write_reg(afsc_pkg::REG_FEED_MODE, m);
      write_reg(afsc_pkg::REG_STEP_DELAY, 0);
      write_reg(afsc_pkg::REG_HOLD_TIME, 0);
      t = '0;
      t.now_ms = 32'hFFFF_FFF0 + m;
      t.trigger_level = 16'sh7FFF;
      t.soft_angle = 32'sh7FFF_FF00;
      t.real_angle = 32'sh8000_0000;
      send_tick(t);
      t.now_ms = t.now_ms + 20;
      send_tick(t);
      t.jam_detected = 1; t.speed_target_negative = 1;
      send_tick(t);
      t.jam_detected = 0;
      t.soft_angle = 32'sh8000_0000;
      send_tick(t);
      t.jam_detected = 1;
      send_tick(t);
      t.jam_detected = 0; t.trigger_level = 16'sh8000;
      send_tick(t);
      drain();
    end
    write_reg(afsc_pkg::REG_STEP_PITCH, 0);
    write_reg(afsc_pkg::REG_FEED_MODE, afsc_pkg::MODE_BURST);
    t = '0; t.now_ms = 500; t.trigger_level = 201; t.soft_angle = 32'sh8000_0000;
    send_tick(t);
    t.trigger_level = 200; t.now_ms = 1000;
    send_tick(t);
    drain();
    for (int ph = 0; ph < 8; ph++) begin
      random_config(ph == 3 || ph == 6);
      calm = (ph == 4);
      for (int i = 0; i < 50; i++) random_tick($urandom_range(9) == 0);
      if (ph == 2) begin
        drain();
        for (int i = 0; i < 5; i++) random_tick(0);
      end
      drain();
    end
    if (sb.errors == 0) $display("ammo_feeder_step_controller test passed");
    else $display("ammo_feeder_step_controller test failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("ammo_feeder_step_controller test failed");
    $finish;
  end
endmodule

// ===== ammo_feeder_step_controller.f =====
src/afsc_pkg.sv
src/afsc_if.sv
src/afsc_div.sv
src/ammo_feeder_step_controller.sv
test/tb_ammo_feeder_step_controller.sv
